// ===== hdl/yl3_pkg.sv =====
// Shared types and constants of the YUY2 luma 3x3 convolution block.
// No dependencies; used by every module under hdl/.
package yl3_pkg;

    // Field and register widths
    localparam int PIX_W        = 8;
    localparam int FRAME_REG_W  = 12;
    localparam int COEF_REG_W   = 36;
    localparam int ROW_W        = 12;
    localparam int CFG_IDX_W    = 3;

    // Tap format: signed, four fraction bits
    localparam int COEF_BITS    = 12;
    localparam int FRAC_BITS    = 4;
    localparam int TAPS         = 3;

    // Arithmetic widths: product, column sum of three, full sum of nine
    localparam int PROD_W       = COEF_BITS + PIX_W + 1;
    localparam int CSUM_W       = PROD_W + 2;
    localparam int TSUM_W       = PROD_W + 4;

    // Default geometry limit for the line stores
    localparam int MAX_WIDTH_DEF = 2048;

    // Register reset values (kernel 0,1,0 / 1,-4,1 / 0,1,0)
    localparam logic [FRAME_REG_W-1:0] WIDTH_RST  = 12'd1920;
    localparam logic [FRAME_REG_W-1:0] HEIGHT_RST = 12'd1080;
    localparam logic [COEF_REG_W-1:0]  COEF_TOP_RST = 36'h000010000;
    localparam logic [COEF_REG_W-1:0]  COEF_MID_RST = 36'h010FC0010;
    localparam logic [COEF_REG_W-1:0]  COEF_BOT_RST = 36'h000010000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_COEF_TOP = 3'd2,
        CFG_COEF_MID = 3'd3,
        CFG_COEF_BOT = 3'd4
    } cfg_idx_t;

    typedef logic [PIX_W-1:0]            pix_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [CSUM_W-1:0]    csum_t;

    // One window column: index 0 row above, 1 current row, 2 row below
    typedef pix_t [TAPS-1:0] col_vec_t;

    // Per-stage enables handed to the window cells
    typedef struct packed {
        logic win_en;
        logic prod_en;
        logic sum_en;
    } cell_ctl_t;

    // Result bookkeeping captured with each released result at the fetch
    typedef struct packed {
        logic       first_col;
        logic       frame_end;
        logic [1:0] top_sel;
        logic [1:0] mid_sel;
        logic [1:0] bot_sel;
    } meta_t;

endpackage

// ===== hdl/yl3_line_store.sv =====
// Three luma row banks (row modulo 3), one write port and two read ports each.
// Read data is registered; the word written this cycle can be forwarded.
// Depends on yl3_pkg.
module yl3_line_store #(
    parameter int MAX_WIDTH = yl3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
    input  yl3_pkg::pix_t                wr_data,
    input  logic                         byp_en,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_a,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_b,
    output yl3_pkg::pix_t                rd_a [3],
    output yl3_pkg::pix_t                rd_b [3]
);

    for (genvar b = 0; b < 3; b++) begin : g_bank
        yl3_pkg::pix_t mem [MAX_WIDTH];
        logic          hit_a;
        logic          hit_b;

        // forward the incoming pixel when it lands on the address being read
        assign hit_a = byp_en && wr_en && (wr_bank == 2'(b)) && (wr_col == rd_col_a);
        assign hit_b = byp_en && wr_en && (wr_bank == 2'(b)) && (wr_col == rd_col_b);

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == 2'(b))) begin
                mem[wr_col] <= wr_data;
            end
            if (rd_en) begin
                rd_a[b] <= hit_a ? wr_data : mem[rd_col_a];
                rd_b[b] <= hit_b ? wr_data : mem[rd_col_b];
            end
        end
    end

endmodule

// ===== hdl/yl3_cell.sv =====
// One column cell of the 3x3 window: holds a column of three pixels,
// multiplies it by its three taps and sums the column. Depends on yl3_pkg.
module yl3_cell (
    input  logic                aclk,
    input  yl3_pkg::cell_ctl_t  ctl,
    input  yl3_pkg::col_vec_t   vec_in,
    input  yl3_pkg::coef_t      taps [3],
    output yl3_pkg::col_vec_t   vec,
    output yl3_pkg::csum_t      col_sum
);

    yl3_pkg::col_vec_t                        vec_reg;
    logic signed [yl3_pkg::PROD_W-1:0]        prod_reg [3];
    yl3_pkg::csum_t                           sum_reg;

    // window column, loaded from the neighbor or from the line stores
    always_ff @(posedge aclk) begin
        if (ctl.win_en) begin
            vec_reg <= vec_in;
        end
    end

    // tap products, pixel taken as a non-negative signed value
    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= yl3_pkg::PROD_W'(taps[i]) *
                               yl3_pkg::PROD_W'($signed({1'b0, vec_reg[i]}));
            end
        end
    end

    // column sum
    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            sum_reg <= yl3_pkg::CSUM_W'(prod_reg[0]) + yl3_pkg::CSUM_W'(prod_reg[1])
                     + yl3_pkg::CSUM_W'(prod_reg[2]);
        end
    end

    assign vec     = vec_reg;
    assign col_sum = sum_reg;

endmodule

// ===== hdl/yuy2_luma_conv3x3.sv =====
// Top level: 3x3 luma convolution over a YUY2 raster stream, border replicated.
// Throughput: one word per clock unless output back-pressure drops s_ready;
// the window cell chain advances once per result.
// Results lag the input by one row plus one pixel; drain words flush the tail.
// Reset restores the register defaults and clears counters and valids;
// the line stores are not cleared. Depends on yl3_pkg, yl3_line_store, yl3_cell.
module yuy2_luma_conv3x3 #(
    parameter int MAX_WIDTH = yl3_pkg::MAX_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [yl3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [yl3_pkg::COEF_REG_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_luma_in,
    input  logic [7:0]                         s_chroma_in,
    input  logic                               s_drain,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_luma_out,
    output logic [7:0]                         m_chroma_out,
    output logic                               m_frame_end
);

    localparam int FW      = yl3_pkg::FRAME_REG_W;
    localparam int RW      = yl3_pkg::ROW_W;
    localparam int CB      = yl3_pkg::COEF_BITS;
    localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int WX      = (MW_BITS > FW ? MW_BITS : FW) + 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int PEND_W  = $clog2(MAX_WIDTH + 2);
    localparam int TW      = yl3_pkg::TSUM_W;

    // ---------------- configuration registers ----------------
    logic [FW-1:0]                    frame_width_reg;
    logic [FW-1:0]                    frame_height_reg;
    logic [yl3_pkg::COEF_REG_W-1:0]   coef_top_reg;
    logic [yl3_pkg::COEF_REG_W-1:0]   coef_mid_reg;
    logic [yl3_pkg::COEF_REG_W-1:0]   coef_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= yl3_pkg::WIDTH_RST;
            frame_height_reg <= yl3_pkg::HEIGHT_RST;
            coef_top_reg     <= yl3_pkg::COEF_TOP_RST;
            coef_mid_reg     <= yl3_pkg::COEF_MID_RST;
            coef_bot_reg     <= yl3_pkg::COEF_BOT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                yl3_pkg::CFG_WIDTH:    frame_width_reg  <= cfg_data[FW-1:0];
                yl3_pkg::CFG_HEIGHT:   frame_height_reg <= cfg_data[FW-1:0];
                yl3_pkg::CFG_COEF_TOP: coef_top_reg     <= cfg_data;
                yl3_pkg::CFG_COEF_MID: coef_mid_reg     <= cfg_data;
                yl3_pkg::CFG_COEF_BOT: coef_bot_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- effective geometry ----------------
    logic [WX-1:0]     w_ext;
    logic [COL_W-1:0]  wm1;
    logic [RW-1:0]     hm1;
    logic [PEND_W-1:0] wp1;
    logic              w_one;

    assign w_ext = {{(WX-FW){1'b0}}, frame_width_reg};

    always_comb begin
        if (w_ext == '0) begin
            wm1 = '0;
        end else if (w_ext > WX'(MAX_WIDTH)) begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = COL_W'(w_ext - WX'(1));
        end
    end

    assign hm1   = (frame_height_reg == '0) ? '0 : RW'(frame_height_reg - FW'(1));
    assign wp1   = PEND_W'(wm1) + PEND_W'(2);
    assign w_one = (wm1 == '0);

    function automatic logic [1:0] m3_inc(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic logic [1:0] m3_dec(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

    // ---------------- position counters ----------------
    logic [COL_W-1:0]  in_col_reg,  out_col_reg;
    logic [RW-1:0]     in_row_reg,  out_row_reg;
    logic [1:0]        in_m3_reg,   out_m3_reg;
    logic              in_done_reg;
    logic [PEND_W-1:0] pend_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic go1, go2, go3, go4, go_out;
    logic acc, is_pix, wr_en, emit, done_after, q_last, frame_done;
    logic in_last_col, in_last_row, out_last_col;

    assign acc          = s_valid && s_ready;
    assign is_pix       = !s_drain && !in_done_reg;
    assign wr_en        = acc && is_pix;
    assign in_last_col  = (in_col_reg == wm1);
    assign in_last_row  = (in_row_reg == hm1);
    assign out_last_col = (out_col_reg == wm1);
    assign q_last       = out_last_col && (out_row_reg == hm1);
    assign done_after   = in_done_reg || (is_pix && in_last_col && in_last_row);

    // a pixel releases a result once a row plus one pixel is pending;
    // after the last pixel every word releases one until the frame is out
    assign emit       = is_pix ? (pend_reg >= wp1) : (in_done_reg && pend_reg != '0);
    assign go1        = acc && emit;
    assign frame_done = go1 && q_last && done_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_m3_reg   <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_m3_reg  <= '0;
            pend_reg    <= '0;
        end else if (frame_done) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_m3_reg   <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_m3_reg  <= '0;
            pend_reg    <= '0;
        end else if (acc) begin
            if (wr_en) begin
                if (in_last_col) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                    in_m3_reg  <= m3_inc(in_m3_reg);
                    if (in_last_row) begin
                        in_done_reg <= 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (go1) begin
                if (out_last_col) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                    out_m3_reg  <= m3_inc(out_m3_reg);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
            pend_reg <= pend_reg + PEND_W'(wr_en) - PEND_W'(go1);
        end
    end

    // ---------------- fetch for the released result ----------------
    yl3_pkg::meta_t   meta_next, meta1_reg;
    logic [COL_W-1:0] rd_col_b;

    assign rd_col_b = out_last_col ? out_col_reg : out_col_reg + COL_W'(1);

    always_comb begin
        meta_next.first_col = (out_col_reg == '0);
        meta_next.frame_end = q_last;
        meta_next.mid_sel   = out_m3_reg;
        meta_next.top_sel   = (out_row_reg == '0) ? out_m3_reg : m3_dec(out_m3_reg);
        meta_next.bot_sel   = (out_row_reg == hm1) ? out_m3_reg : m3_inc(out_m3_reg);
    end

    yl3_pkg::pix_t rd_a [3];
    yl3_pkg::pix_t rd_b [3];

    yl3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_bank  (in_m3_reg),
        .wr_col   (in_col_reg),
        .wr_data  (s_luma_in),
        .byp_en   (!w_one),
        .rd_en    (go1),
        .rd_col_a (out_col_reg),
        .rd_col_b (rd_col_b),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    // chroma delay, two rows addressed by row parity and column (read-first)
    yl3_pkg::pix_t chroma_mem [2*MAX_WIDTH];
    yl3_pkg::pix_t chroma1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            chroma_mem[{in_row_reg[0], in_col_reg}] <= s_chroma_in;
        end
        if (go1) begin
            chroma1_reg <= chroma_mem[{out_row_reg[0], out_col_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (go1) begin
            meta1_reg <= meta_next;
        end
    end

    // ---------------- stage handshakes ----------------
    assign go_out  = v4_reg && (!m_valid_reg || m_ready);
    assign go4     = v3_reg && (!v4_reg || go_out);
    assign go3     = v2_reg && (!v3_reg || go4);
    assign go2     = v1_reg && (!v2_reg || go3);
    assign s_ready = !v1_reg || go2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= go1    || (v1_reg && !go2);
            v2_reg      <= go2    || (v2_reg && !go3);
            v3_reg      <= go3    || (v3_reg && !go4);
            v4_reg      <= go4    || (v4_reg && !go_out);
            m_valid_reg <= go_out || (m_valid_reg && !m_ready);
        end
    end

    // ---------------- bank to row mapping ----------------
    function automatic yl3_pkg::pix_t pick(input logic [1:0] sel,
                                           input yl3_pkg::pix_t b0,
                                           input yl3_pkg::pix_t b1,
                                           input yl3_pkg::pix_t b2);
        yl3_pkg::pix_t r;
        unique case (sel)
            2'd0:    r = b0;
            2'd1:    r = b1;
            default: r = b2;
        endcase
        return r;
    endfunction

    yl3_pkg::col_vec_t vec_a, vec_b;

    always_comb begin
        vec_a[0] = pick(meta1_reg.top_sel, rd_a[0], rd_a[1], rd_a[2]);
        vec_a[1] = pick(meta1_reg.mid_sel, rd_a[0], rd_a[1], rd_a[2]);
        vec_a[2] = pick(meta1_reg.bot_sel, rd_a[0], rd_a[1], rd_a[2]);
        vec_b[0] = pick(meta1_reg.top_sel, rd_b[0], rd_b[1], rd_b[2]);
        vec_b[1] = pick(meta1_reg.mid_sel, rd_b[0], rd_b[1], rd_b[2]);
        vec_b[2] = pick(meta1_reg.bot_sel, rd_b[0], rd_b[1], rd_b[2]);
    end

    // ---------------- window cell chain ----------------
    yl3_pkg::cell_ctl_t ctl;
    yl3_pkg::col_vec_t  cell_in  [3];
    yl3_pkg::col_vec_t  cell_vec [3];
    yl3_pkg::csum_t     cell_sum [3];
    yl3_pkg::coef_t     cell_taps [3][3];

    assign ctl = '{win_en: go2, prod_en: go3, sum_en: go4};

    // at a row start the left border column is replicated
    assign cell_in[0] = meta1_reg.first_col ? vec_a : cell_vec[1];
    assign cell_in[1] = meta1_reg.first_col ? vec_a : cell_vec[2];
    assign cell_in[2] = vec_b;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        assign cell_taps[k][0] = coef_top_reg[k*CB +: CB];
        assign cell_taps[k][1] = coef_mid_reg[k*CB +: CB];
        assign cell_taps[k][2] = coef_bot_reg[k*CB +: CB];

        yl3_cell u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .vec_in  (cell_in[k]),
            .taps    (cell_taps[k]),
            .vec     (cell_vec[k]),
            .col_sum (cell_sum[k])
        );
    end

    // chroma and frame end ride along with the window
    yl3_pkg::pix_t chroma2_reg, chroma3_reg, chroma4_reg;
    logic          fend2_reg, fend3_reg, fend4_reg;

    always_ff @(posedge aclk) begin
        if (go2) begin
            chroma2_reg <= chroma1_reg;
            fend2_reg   <= meta1_reg.frame_end;
        end
        if (go3) begin
            chroma3_reg <= chroma2_reg;
            fend3_reg   <= fend2_reg;
        end
        if (go4) begin
            chroma4_reg <= chroma3_reg;
            fend4_reg   <= fend3_reg;
        end
    end

    // ---------------- final sum, truncate toward zero, saturate ----------------
    logic signed [TW-1:0] total;
    logic [TW-1:0]        scaled;
    yl3_pkg::pix_t        luma_sat;

    assign total  = TW'(cell_sum[0]) + TW'(cell_sum[1]) + TW'(cell_sum[2]);
    assign scaled = TW'(total >>> yl3_pkg::FRAC_BITS);

    // a negative sum truncates to zero or below, so it clips to zero
    always_comb begin
        if (total < 0) begin
            luma_sat = '0;
        end else if (scaled > TW'(255)) begin
            luma_sat = 8'hFF;
        end else begin
            luma_sat = scaled[7:0];
        end
    end

    yl3_pkg::pix_t luma_out_reg, chroma_out_reg;
    logic          fend_out_reg;

    always_ff @(posedge aclk) begin
        if (go_out) begin
            luma_out_reg   <= luma_sat;
            chroma_out_reg <= chroma4_reg;
            fend_out_reg   <= fend4_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_luma_out   = luma_out_reg;
    assign m_chroma_out = chroma_out_reg;
    assign m_frame_end  = fend_out_reg;

    // ---------------- assertions ----------------
    // pending pixels never exceed one row plus one
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= wp1)
        else $error("pending count beyond one row plus one pixel");

    // a result is released only when something is pending
    a_emit_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        go1 |-> pend_reg != '0)
        else $error("result released with nothing pending");

    // the last result of a frame rewinds all position counters
    a_frame_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (out_col_reg == '0) && (out_row_reg == '0) &&
                       (pend_reg == '0) && !in_done_reg)
        else $error("counters not rewound after frame end");

endmodule
